// ===== rtl/pwam_pkg.sv =====
// ----------------------------------------------------------------------------
// pwam_pkg
// Shared types and constants of the perspective warp address map.
// ----------------------------------------------------------------------------
package pwam_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned DimW   = 13;
  localparam int unsigned CoefW  = 32;
  localparam int unsigned ProdW  = CoefW + CoordW + 1;
  localparam int unsigned AccW   = 48;
  localparam int unsigned DenW   = AccW - 1;
  localparam int unsigned CmpW   = AccW + CoordW;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned DataW  = 64;

  localparam logic [IdxW-1:0] RegCoefA  = 3'd0;
  localparam logic [IdxW-1:0] RegCoefB  = 3'd1;
  localparam logic [IdxW-1:0] RegCoefC  = 3'd2;
  localparam logic [IdxW-1:0] RegCoefD  = 3'd3;
  localparam logic [IdxW-1:0] RegCoefE  = 3'd4;
  localparam logic [IdxW-1:0] RegWidth  = 3'd5;
  localparam logic [IdxW-1:0] RegHeight = 3'd6;

  typedef struct packed {
    logic [8:0][CoefW-1:0] m;
    logic [DimW-1:0]       img_w;
    logic [DimW-1:0]       img_h;
  } pwam_cfg_t;

  typedef struct packed {
    logic [AccW-1:0]   rem_u;
    logic [AccW-1:0]   rem_v;
    logic [DenW-1:0]   den;
    logic [CoordW-1:0] qx;
    logic [CoordW-1:0] qy;
    logic              bad;
  } pwam_div_t;

endpackage

// ===== rtl/pwam_if.sv =====
// ----------------------------------------------------------------------------
// pwam_if
// Handshake channels of the perspective warp address map.
// ----------------------------------------------------------------------------
interface pwam_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] dest_x;
  logic [11:0] dest_y;
  modport source (output valid, dest_x, dest_y, input ready);
  modport sink (input valid, dest_x, dest_y, output ready);
endinterface

interface pwam_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] src_x;
  logic [11:0] src_y;
  logic        src_valid;
  modport source (output valid, src_x, src_y, src_valid, input ready);
  modport sink (input valid, src_x, src_y, src_valid, output ready);
endinterface

interface pwam_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/pwam_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pwam_cfg_regs
// Configuration registers: homography coefficients and image size.
// ----------------------------------------------------------------------------
module pwam_cfg_regs import pwam_pkg::*; #(
  parameter int unsigned MAX_DIM        = 4096,
  parameter int unsigned COEF_FRAC_BITS = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  logic [IdxW-1:0]  wr_index_i,
  input  logic [DataW-1:0] wr_data_i,
  output pwam_cfg_t        cfg_o
);

  localparam logic [CoefW-1:0] One  = CoefW'(64'd1 << COEF_FRAC_BITS);
  localparam logic [DimW-1:0]  MaxD = DimW'(MAX_DIM);
  localparam logic [8:0][CoefW-1:0] MReset = {One, {3{{CoefW{1'b0}}}}, One,
                                              {3{{CoefW{1'b0}}}}, One};

  pwam_cfg_t       cfg_q;
  logic [DimW-1:0] dim_d;

  assign dim_d = (wr_data_i[DimW-1:0] > MaxD) ? MaxD : wr_data_i[DimW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.m     <= MReset;
      cfg_q.img_w <= MaxD;
      cfg_q.img_h <= MaxD;
    end else if (wr_valid_i) begin
      case (wr_index_i)
        RegCoefA: begin
          cfg_q.m[0] <= wr_data_i[31:0];
          cfg_q.m[1] <= wr_data_i[63:32];
        end
        RegCoefB: begin
          cfg_q.m[2] <= wr_data_i[31:0];
          cfg_q.m[3] <= wr_data_i[63:32];
        end
        RegCoefC: begin
          cfg_q.m[4] <= wr_data_i[31:0];
          cfg_q.m[5] <= wr_data_i[63:32];
        end
        RegCoefD: begin
          cfg_q.m[6] <= wr_data_i[31:0];
          cfg_q.m[7] <= wr_data_i[63:32];
        end
        RegCoefE:  cfg_q.m[8]  <= wr_data_i[31:0];
        RegWidth:  cfg_q.img_w <= dim_d;
        RegHeight: cfg_q.img_h <= dim_d;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/pwam_dot.sv =====
// ----------------------------------------------------------------------------
// pwam_dot
// Four-stage front end: input capture, products, sums, sign normalization.
// ----------------------------------------------------------------------------
module pwam_dot import pwam_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pwam_cfg_t         cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [CoordW-1:0] x_i,
  input  logic [CoordW-1:0] y_i,
  output logic              valid_o,
  input  logic              ready_i,
  output pwam_div_t         data_o
);

  logic [3:0] v_q;
  logic [4:0] rdy;

  logic [CoordW-1:0]            x_q, y_q;
  logic signed [5:0][ProdW-1:0] p_q;
  logic signed [AccW-1:0]       u_q, vv_q, w_q;
  pwam_div_t                    n_q;

  logic signed [ProdW-1:0] p_d [6];
  logic signed [AccW-1:0]  u_d, vv_d, w_d;
  logic signed [AccW-1:0]  nu, nv, nw;
  logic [CmpW-1:0]         lim;
  pwam_div_t               n_d;

  assign rdy[4] = ready_i;
  for (genvar k = 0; k < 4; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign ready_o = rdy[0];
  assign valid_o = v_q[3];
  assign data_o  = n_q;

  always_comb begin
    p_d[0] = ProdW'($signed(cfg_i.m[0])) * ProdW'($signed({1'b0, x_q}));
    p_d[1] = ProdW'($signed(cfg_i.m[1])) * ProdW'($signed({1'b0, y_q}));
    p_d[2] = ProdW'($signed(cfg_i.m[3])) * ProdW'($signed({1'b0, x_q}));
    p_d[3] = ProdW'($signed(cfg_i.m[4])) * ProdW'($signed({1'b0, y_q}));
    p_d[4] = ProdW'($signed(cfg_i.m[6])) * ProdW'($signed({1'b0, x_q}));
    p_d[5] = ProdW'($signed(cfg_i.m[7])) * ProdW'($signed({1'b0, y_q}));
    u_d  = AccW'($signed(p_q[0])) + AccW'($signed(p_q[1])) + AccW'($signed(cfg_i.m[2]));
    vv_d = AccW'($signed(p_q[2])) + AccW'($signed(p_q[3])) + AccW'($signed(cfg_i.m[5]));
    w_d  = AccW'($signed(p_q[4])) + AccW'($signed(p_q[5])) + AccW'($signed(cfg_i.m[8]));
    nu = w_q[AccW-1] ? -u_q  : u_q;
    nv = w_q[AccW-1] ? -vv_q : vv_q;
    nw = w_q[AccW-1] ? -w_q  : w_q;
    lim = CmpW'(nw) << CoordW;
    n_d.rem_u = nu;
    n_d.rem_v = nv;
    n_d.den   = nw[DenW-1:0];
    n_d.qx    = '0;
    n_d.qy    = '0;
    n_d.bad   = (w_q == '0) || nu[AccW-1] || nv[AccW-1] ||
                (CmpW'(nu) >= lim) || (CmpW'(nv) >= lim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < 4; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      x_q <= x_i;
      y_q <= y_i;
    end
    if (rdy[1] && v_q[0]) begin
      for (int k = 0; k < 6; k++) p_q[k] <= p_d[k];
    end
    if (rdy[2] && v_q[1]) begin
      u_q  <= u_d;
      vv_q <= vv_d;
      w_q  <= w_d;
    end
    if (rdy[3] && v_q[2]) begin
      n_q <= n_d;
    end
  end

endmodule

// ===== rtl/pwam_div_step.sv =====
// ----------------------------------------------------------------------------
// pwam_div_step
// One registered restoring step of the two floor divisions by w.
// ----------------------------------------------------------------------------
module pwam_div_step import pwam_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  pwam_div_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output pwam_div_t data_o
);

  logic      valid_q;
  pwam_div_t data_q;
  pwam_div_t data_d;
  logic [CmpW-1:0] sh;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    sh     = CmpW'(data_i.den) << BIT;
    data_d = data_i;
    if (CmpW'(data_i.rem_u) >= sh) begin
      data_d.rem_u   = data_i.rem_u - sh[AccW-1:0];
      data_d.qx[BIT] = 1'b1;
    end
    if (CmpW'(data_i.rem_v) >= sh) begin
      data_d.rem_v   = data_i.rem_v - sh[AccW-1:0];
      data_d.qy[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

endmodule

// ===== rtl/perspective_warp_address_map_core.sv =====
// ----------------------------------------------------------------------------
// perspective_warp_address_map_core
// Maps destination pixels to source pixels through an inverse homography.
// ----------------------------------------------------------------------------
// The dest channel takes one destination coordinate word per cycle while it is
// ready. The src channel returns one word per input, in order, with the
// source coordinate and a flag that is low when w is zero or the point falls
// outside the image. The cfg channel writes the coefficient and image size
// registers; it is always ready, and the user must write it only while no
// word is in flight; the block does not enforce this. The pipeline has four
// front-end stages (capture, products, sums, sign normalization), twelve
// divider stages that each resolve one quotient bit of both divisions, and
// the output register. Throughput, set by the one-bit-per-stage divider
// pipeline, is one word per cycle while the receiver accepts. Reset empties
// the pipeline and loads the identity matrix with a 4096 by 4096 image. When
// the receiver stalls, each stage holds its word while empty stages upstream
// keep filling, so the dest channel stays ready until the pipeline is full.
// ----------------------------------------------------------------------------
module perspective_warp_address_map_core import pwam_pkg::*; #(
  parameter int unsigned MAX_DIM        = 4096,
  parameter int unsigned COEF_FRAC_BITS = 20
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pwam_in_if.sink    dest_i,
  pwam_cfg_if.sink   cfg_i,
  pwam_out_if.source src_o
);

  pwam_cfg_t cfg;

  logic            dv   [CoordW+1];
  logic            drdy [CoordW+1];
  pwam_div_t       dd   [CoordW+1];
  logic            out_rdy;
  logic            out_v_q;
  logic [CoordW-1:0] sx_q, sy_q;
  logic            ok_q;
  logic            ok_d;
  pwam_div_t       fin;

  assign cfg_i.ready = 1'b1;

  pwam_cfg_regs #(
    .MAX_DIM        (MAX_DIM),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  pwam_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (dest_i.valid),
    .ready_o (dest_i.ready),
    .x_i     (dest_i.dest_x),
    .y_i     (dest_i.dest_y),
    .valid_o (dv[0]),
    .ready_i (drdy[0]),
    .data_o  (dd[0])
  );

  for (genvar k = 0; k < CoordW; k++) begin : g_div
    pwam_div_step #(.BIT(CoordW - 1 - k)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[k]),
      .ready_o (drdy[k]),
      .data_i  (dd[k]),
      .valid_o (dv[k+1]),
      .ready_i (drdy[k+1]),
      .data_o  (dd[k+1])
    );
  end

  assign fin           = dd[CoordW];
  assign out_rdy       = !out_v_q || src_o.ready;
  assign drdy[CoordW]  = out_rdy;
  assign ok_d = !fin.bad && ({1'b0, fin.qx} < cfg.img_w) && ({1'b0, fin.qy} < cfg.img_h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= dv[CoordW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && dv[CoordW]) begin
      ok_q <= ok_d;
      sx_q <= ok_d ? fin.qx : '0;
      sy_q <= ok_d ? fin.qy : '0;
    end
  end

  assign src_o.valid     = out_v_q;
  assign src_o.src_x     = sx_q;
  assign src_o.src_y     = sy_q;
  assign src_o.src_valid = ok_q;

  a_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (src_o.valid && src_o.src_valid) |->
      (({1'b0, src_o.src_x} < cfg.img_w) && ({1'b0, src_o.src_y} < cfg.img_h)))
    else $error("source coordinate outside the image");

  a_zero_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (src_o.valid && !src_o.src_valid) |-> (src_o.src_x == '0 && src_o.src_y == '0))
    else $error("invalid word carries a nonzero coordinate");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv[CoordW] && !out_rdy) |=> dv[CoordW])
    else $error("divider output lost while the output register was full");

endmodule
